FILE: hdl/lpmr_pkg.sv
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared types and constants of the length-prefixed message ring: operation
// and status codes, command classes and the command record between stages.
// ----------------------------------------------------------------------------
package lpmr_pkg;

	// default ring size in bytes and fixed header size
	localparam int QUEUE_BYTES_DEF = 4096;
	localparam int HEADER_BYTES    = 4;

	// payload widths
	localparam int OP_W     = 2;
	localparam int LEN_W    = 12;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 10;
	localparam int USED_W   = 12;

	// depth of the queue between front and back
	localparam int CMDQ_DEPTH = 2;

	// operation codes on the input channel
	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// status codes on the result channel
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

	// command class decided by the front
	typedef enum logic [1:0] {
		CMD_START,
		CMD_BYTE,
		CMD_READ,
		CMD_BAD
	} cmd_kind_t;

	// one classified transaction
	typedef struct packed {
		cmd_kind_t          kind;
		logic [LEN_W-1:0]   len;
		logic [BYTE_W-1:0]  data;
	} cmd_t;

endpackage

FILE: hdl/lpmr_if.sv
// ----------------------------------------------------------------------------
// lpmr_if
// Valid/ready channels of the message ring: the command channel and the
// result channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface lpmr_in_if;
	logic                        valid;
	logic                        ready;
	logic [lpmr_pkg::OP_W-1:0]   operation;
	logic [lpmr_pkg::LEN_W-1:0]  msg_length;
	logic [lpmr_pkg::BYTE_W-1:0] data_in;

	modport source (output valid, operation, msg_length, data_in, input ready);
	modport sink (input valid, operation, msg_length, data_in, output ready);
endinterface

interface lpmr_out_if;
	logic                          valid;
	logic                          ready;
	logic [lpmr_pkg::STATUS_W-1:0] status;
	logic [lpmr_pkg::BYTE_W-1:0]   data_out;
	logic                          byte_valid;
	logic                          last_of_message;
	logic [lpmr_pkg::COUNT_W-1:0]  message_count;
	logic [lpmr_pkg::USED_W-1:0]   used_bytes;

	modport source (output valid, status, data_out, byte_valid, last_of_message,
		message_count, used_bytes, input ready);
	modport sink (input valid, status, data_out, byte_valid, last_of_message,
		message_count, used_bytes, output ready);
endinterface

FILE: hdl/lpmr_ram.sv
// ----------------------------------------------------------------------------
// lpmr_ram
// Generic single-port RAM with registered read data. Read data holds while
// the port is not enabled.
// ----------------------------------------------------------------------------
module lpmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one access per cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

FILE: hdl/lpmr_front.sv
// ----------------------------------------------------------------------------
// lpmr_front
// Front stage: accepts input transactions and classifies the operation
// into a command record held in a pipeline register.
// ----------------------------------------------------------------------------
module lpmr_front (
	input  logic               clk,
	input  logic               arst_n,
	lpmr_in_if.sink            cmd,
	output logic               cmd_vld_s1,
	output lpmr_pkg::cmd_t     cmd_s1,
	input  logic               cmd_rdy
);

	lpmr_pkg::cmd_kind_t kind;

	// operation decode
	always_comb begin
		unique case (cmd.operation)
			lpmr_pkg::OP_START: kind = lpmr_pkg::CMD_START;
			lpmr_pkg::OP_BYTE:  kind = lpmr_pkg::CMD_BYTE;
			lpmr_pkg::OP_READ:  kind = lpmr_pkg::CMD_READ;
			default:            kind = lpmr_pkg::CMD_BAD;
		endcase
	end

	assign cmd.ready = !cmd_vld_s1 || cmd_rdy;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			cmd_vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1.kind <= kind;
			cmd_s1.len  <= cmd.msg_length;
			cmd_s1.data <= cmd.data_in;
		end
	end

endmodule

FILE: hdl/lpmr_queue.sv
// ----------------------------------------------------------------------------
// lpmr_queue
// Short command queue between front and back so that each side stalls on
// its own.
// ----------------------------------------------------------------------------
module lpmr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_vld,
	input  lpmr_pkg::cmd_t push_cmd,
	output logic           push_rdy,
	output logic           pop_vld,
	output lpmr_pkg::cmd_t pop_cmd,
	input  logic           pop_rdy
);

	localparam int PW = $clog2(lpmr_pkg::CMDQ_DEPTH);
	localparam int CW = $clog2(lpmr_pkg::CMDQ_DEPTH + 1);

	lpmr_pkg::cmd_t entry_q [lpmr_pkg::CMDQ_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign push_rdy = count_q != CW'(lpmr_pkg::CMDQ_DEPTH);
	assign pop_vld  = count_q != '0;
	assign pop_cmd  = entry_q[rd_ptr_q];
	assign do_push  = push_vld && push_rdy;
	assign do_pop   = pop_vld && pop_rdy;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(lpmr_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(lpmr_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: hdl/lpmr_back.sv
// ----------------------------------------------------------------------------
// lpmr_back
// Back end: carries out commands against the ring memory, keeps the ring
// pointers and message bookkeeping, and holds the result register.
// ----------------------------------------------------------------------------
module lpmr_back #(
	parameter int QUEUE_BYTES = lpmr_pkg::QUEUE_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_vld,
	input  lpmr_pkg::cmd_t q_cmd,
	output logic           q_pop,
	lpmr_out_if.source     rsp
);

	localparam int AW = $clog2(QUEUE_BYTES);
	localparam int UW = (AW > lpmr_pkg::USED_W) ? AW : lpmr_pkg::USED_W;
	localparam int WW = (AW > lpmr_pkg::COUNT_W) ? AW : lpmr_pkg::COUNT_W;
	localparam int LW = lpmr_pkg::LEN_W;
	localparam int BW = lpmr_pkg::BYTE_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR,
		S_RD_H0,
		S_RD_H1,
		S_RD_Z,
		S_RD_DATA
	} state_t;

	typedef enum logic [1:0] {
		PS_IDLE,
		PS_FILL,
		PS_DROP
	} push_st_t;

	// state registers
	state_t          state_q, state_d;
	push_st_t        push_st_q, push_st_d;
	logic [AW-1:0]   head_q, head_d;
	logic [AW-1:0]   tail_q, tail_d;
	logic [UW-1:0]   used_q, used_d;
	logic [WW-1:0]   wait_q, wait_d;
	logic [LW-1:0]   push_rem_q, push_rem_d;
	logic [LW-1:0]   rd_rem_q, rd_rem_d;
	logic            rd_open_q, rd_open_d;
	logic [1:0]      hdr_k_q, hdr_k_d;
	logic [BW-1:0]   len_lo_q, len_lo_d;

	// result register
	logic                              out_vld_q;
	logic [lpmr_pkg::STATUS_W-1:0]     status_q;
	logic [BW-1:0]                     data_out_q;
	logic                              byte_valid_q;
	logic                              last_q;
	logic [lpmr_pkg::COUNT_W-1:0]      count_q;
	logic [lpmr_pkg::USED_W-1:0]       used_out_q;

	// step outputs
	logic                              want;
	logic                              fin;
	logic                              out_free;
	logic [lpmr_pkg::STATUS_W-1:0]     st;
	logic [BW-1:0]                     dout;
	logic                              bv;
	logic                              last;
	logic                              refuse;
	logic [LW-1:0]                     rd_len;

	// memory port
	logic            ram_en;
	logic            ram_we;
	logic [AW-1:0]   ram_addr;
	logic [BW-1:0]   ram_wd;
	logic [BW-1:0]   ram_rd;

	// pointer advance with wrap around the ring
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [2:0] k);
		logic [AW:0] s;
		s = {1'b0, p} + (AW+1)'(k);
		if (s >= (AW+1)'(QUEUE_BYTES)) begin
			s = s - (AW+1)'(QUEUE_BYTES);
		end
		return s[AW-1:0];
	endfunction

	// little-endian header byte for a 12-bit length
	function automatic logic [BW-1:0] hdr_byte(input logic [LW-1:0] len, input logic [1:0] k);
		logic [BW-1:0] b;
		b = '0;
		if (k == 2'd0) begin
			b = len[BW-1:0];
		end else if (k == 2'd1) begin
			b = BW'(len[LW-1:BW]);
		end
		return b;
	endfunction

	lpmr_ram #(
		.WIDTH(BW),
		.DEPTH(QUEUE_BYTES)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wd),
		.rdata(ram_rd)
	);

	assign out_free = !out_vld_q || rsp.ready;
	assign fin      = want && out_free;
	assign q_pop    = fin;
	assign rd_len   = {ram_rd[LW-BW-1:0], len_lo_q};
	assign refuse   = ({2'b00, used_q} + (UW+2)'(q_cmd.len) + (UW+2)'(lpmr_pkg::HEADER_BYTES))
		> (UW+2)'(QUEUE_BYTES - 1);

	// command sequencing; bookkeeping commits on the finishing cycle, except that a read takes the header off in S_RD_H1
	always_comb begin
		state_d    = state_q;
		push_st_d  = push_st_q;
		head_d     = head_q;
		tail_d     = tail_q;
		used_d     = used_q;
		wait_d     = wait_q;
		push_rem_d = push_rem_q;
		rd_rem_d   = rd_rem_q;
		rd_open_d  = rd_open_q;
		hdr_k_d    = hdr_k_q;
		len_lo_d   = len_lo_q;
		want       = 1'b0;
		st         = lpmr_pkg::ST_OK;
		dout       = '0;
		bv         = 1'b0;
		last       = 1'b0;
		ram_en     = 1'b0;
		ram_we     = 1'b0;
		ram_addr   = tail_q;
		ram_wd     = q_cmd.data;

		unique case (state_q)
			S_IDLE: begin
				if (q_vld) begin
					unique case (q_cmd.kind)
						lpmr_pkg::CMD_START: begin
							if (push_st_q != PS_IDLE) begin
								want = 1'b1;
								st   = lpmr_pkg::ST_IGNORED;
							end else if (refuse) begin
								want = 1'b1;
								st   = lpmr_pkg::ST_FULL;
								if (out_free && q_cmd.len != '0) begin
									push_st_d  = PS_DROP;
									push_rem_d = q_cmd.len;
								end
							end else begin
								ram_en   = 1'b1;
								ram_we   = 1'b1;
								ram_addr = tail_q;
								ram_wd   = hdr_byte(q_cmd.len, 2'd0);
								hdr_k_d  = 2'd1;
								state_d  = S_HDR;
							end
						end
						lpmr_pkg::CMD_BYTE: begin
							want = 1'b1;
							if (push_st_q == PS_IDLE) begin
								st = lpmr_pkg::ST_IGNORED;
							end else begin
								if (push_st_q != PS_FILL) begin
									st = lpmr_pkg::ST_FULL;
								end
								if (out_free) begin
									if (push_st_q == PS_FILL) begin
										ram_en = 1'b1;
										ram_we = 1'b1;
										tail_d = wrap_add(tail_q, 3'd1);
										used_d = used_q + 1'b1;
									end
									push_rem_d = push_rem_q - 1'b1;
									if (push_rem_q == LW'(1)) begin
										push_st_d = PS_IDLE;
										if (push_st_q == PS_FILL) begin
											wait_d = wait_q + 1'b1;
										end
									end
								end
							end
						end
						lpmr_pkg::CMD_READ: begin
							if (rd_open_q) begin
								ram_en   = 1'b1;
								ram_addr = head_q;
								state_d  = S_RD_DATA;
							end else if (wait_q == '0) begin
								want = 1'b1;
								st   = lpmr_pkg::ST_EMPTY;
							end else begin
								ram_en   = 1'b1;
								ram_addr = head_q;
								state_d  = S_RD_H0;
							end
						end
						default: begin
							want = 1'b1;
							st   = lpmr_pkg::ST_IGNORED;
						end
					endcase
				end
			end
			S_HDR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = wrap_add(tail_q, {1'b0, hdr_k_q});
				ram_wd   = hdr_byte(q_cmd.len, hdr_k_q);
				if (hdr_k_q == 2'd3) begin
					want = 1'b1;
					if (out_free) begin
						tail_d = wrap_add(tail_q, 3'(lpmr_pkg::HEADER_BYTES));
						used_d = used_q + UW'(lpmr_pkg::HEADER_BYTES);
						if (q_cmd.len == '0) begin
							wait_d = wait_q + 1'b1;
						end else begin
							push_st_d  = PS_FILL;
							push_rem_d = q_cmd.len;
						end
						state_d = S_IDLE;
					end
				end else begin
					hdr_k_d = hdr_k_q + 1'b1;
				end
			end
			S_RD_H0: begin
				ram_en   = 1'b1;
				ram_addr = wrap_add(head_q, 3'd1);
				len_lo_d = ram_rd;
				state_d  = S_RD_H1;
			end
			S_RD_H1: begin
				head_d   = wrap_add(head_q, 3'(lpmr_pkg::HEADER_BYTES));
				used_d   = used_q - UW'(lpmr_pkg::HEADER_BYTES);
				wait_d   = wait_q - 1'b1;
				rd_rem_d = rd_len;
				if (rd_len == '0) begin
					state_d = S_RD_Z;
				end else begin
					rd_open_d = 1'b1;
					ram_en    = 1'b1;
					ram_addr  = wrap_add(head_q, 3'(lpmr_pkg::HEADER_BYTES));
					state_d   = S_RD_DATA;
				end
			end
			S_RD_Z: begin
				want = 1'b1;
				last = 1'b1;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_RD_DATA: begin
				want = 1'b1;
				bv   = 1'b1;
				dout = ram_rd;
				last = rd_rem_q == LW'(1);
				if (out_free) begin
					head_d   = wrap_add(head_q, 3'd1);
					used_d   = used_q - 1'b1;
					rd_rem_d = rd_rem_q - 1'b1;
					if (rd_rem_q == LW'(1)) begin
						rd_open_d = 1'b0;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			push_st_q  <= PS_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			used_q     <= '0;
			wait_q     <= '0;
			push_rem_q <= '0;
			rd_rem_q   <= '0;
			rd_open_q  <= 1'b0;
			hdr_k_q    <= '0;
			len_lo_q   <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			push_st_q  <= push_st_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			used_q     <= used_d;
			wait_q     <= wait_d;
			push_rem_q <= push_rem_d;
			rd_rem_q   <= rd_rem_d;
			rd_open_q  <= rd_open_d;
			hdr_k_q    <= hdr_k_d;
			len_lo_q   <= len_lo_d;
			if (fin) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fin) begin
			status_q     <= st;
			data_out_q   <= dout;
			byte_valid_q <= bv;
			last_q       <= last;
			count_q      <= (wait_d > WW'(1023)) ? 10'd1023 : wait_d[lpmr_pkg::COUNT_W-1:0];
			used_out_q   <= used_d[lpmr_pkg::USED_W-1:0];
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.status          = status_q;
	assign rsp.data_out        = data_out_q;
	assign rsp.byte_valid      = byte_valid_q;
	assign rsp.last_of_message = last_q;
	assign rsp.message_count   = count_q;
	assign rsp.used_bytes      = used_out_q;

	// a data read always belongs to an open message with bytes left
	a_rd_data_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD_DATA |-> rd_open_q && rd_rem_q != '0)
		else $error("data read without an open message");

	// an open push always expects at least one more byte
	a_push_rem: assert property (@(posedge clk) disable iff (!arst_n)
		push_st_q != PS_IDLE |-> push_rem_q != '0)
		else $error("open push with nothing remaining");

	// a finished command always shows up in the result register
	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> out_vld_q)
		else $error("finished command without a result");

	// the ring never fills beyond its usable size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(QUEUE_BYTES - 1))
		else $error("ring occupancy over limit");

endmodule

FILE: hdl/length_prefixed_message_ring_core.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_core
// Circular byte store of length-prefixed messages: a front stage classifies
// commands, a short queue decouples it from the back end, which works on a
// single-port ring memory and holds the result register.
//
//  channel  dir  payload                                        handshake
//  cmd      in   operation, msg_length, data_in                 valid/ready
//  rsp      out  status, data_out, byte_valid, last_of_message, valid/ready
//                message_count, used_bytes
//
// Back-end steps on the single memory port: a data byte, a refused or ignored
// command or an empty read ends in S_IDLE; an accepted start push writes one
// header byte per cycle through S_HDR; a read first reads the header (S_RD_H0,
// S_RD_H1) if it opens a message, then gives a byte from S_RD_DATA, or S_RD_Z
// for an empty message. Reset clears control state, not the ring memory. The
// front keeps accepting while the back or rsp stalls, until the queue fills.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_core #(
	parameter int QUEUE_BYTES = lpmr_pkg::QUEUE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lpmr_in_if.sink     cmd,
	lpmr_out_if.source  rsp
);

	logic           f_vld_s1;
	lpmr_pkg::cmd_t f_cmd_s1;
	logic           f_rdy;
	logic           q_vld;
	lpmr_pkg::cmd_t q_cmd;
	logic           q_pop;

	// classify incoming transactions
	lpmr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_vld_s1(f_vld_s1),
		.cmd_s1    (f_cmd_s1),
		.cmd_rdy   (f_rdy)
	);

	// decoupling queue
	lpmr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_vld(f_vld_s1),
		.push_cmd(f_cmd_s1),
		.push_rdy(f_rdy),
		.pop_vld (q_vld),
		.pop_cmd (q_cmd),
		.pop_rdy (q_pop)
	);

	// execute against the ring
	lpmr_back #(
		.QUEUE_BYTES(QUEUE_BYTES)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.q_vld (q_vld),
		.q_cmd (q_cmd),
		.q_pop (q_pop),
		.rsp   (rsp)
	);

endmodule
